FILE: src/ucb1_tuned_child_select_macros.svh
// Assertion macros for the child select block and its checker.
// Uses the clk and rst names of the module that expands them.
`ifndef UCB1_TUNED_CHILD_SELECT_MACROS_SVH
`define UCB1_TUNED_CHILD_SELECT_MACROS_SVH
// same-cycle implication
`define UCBTS_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("ucbts check failed");
// next-cycle implication
`define UCBTS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("ucbts check failed");
`endif

FILE: src/ucbts_pkg.sv
// Constants shared by the child select block and its checker.
// No dependencies.
package ucbts_pkg;
  localparam int MAX_CHILDREN = 512;
  localparam int IDX_W        = $clog2(MAX_CHILDREN);
  localparam int URG_W        = 23;
  localparam logic signed [URG_W-1:0] URG_MAX = 23'sd4194303;
  localparam logic signed [URG_W-1:0] URG_MIN = -23'sd4194304;
  localparam logic [15:0] GAIN_RESET  = 16'd819;
  localparam logic [15:0] LN2_Q16     = 16'd45426;
  localparam logic [14:0] QUARTER_Q16 = 15'd16384;
  localparam logic [4:0]  LN_STEPS    = 5'd16;
  localparam logic [4:0]  DIV_STEPS   = 5'd25;
  localparam logic [4:0]  SQRT_STEPS  = 5'd21;
endpackage

FILE: src/ucb1_tuned_child_select.sv
// UCB1-tuned child selection, top level.
// Depends on ucbts_pkg.
//
// Children of one node arrive one item at a time; the block is busy with each
// considered child (16 log squarings, 4 multiplies, two
// 25-step divisions and two 21-step square roots, plus set-up states),
// all sequenced through one 32x32 multiplier and one 43-bit subtractor.
// Skipped pass children, children with zero visits and a zero parent count go
// straight to the update state. in_stall is high while a child is being worked
// on. The result for a node is registered on the last child and may wait on
// out_stall while the next node's first child is already accepted.
module ucb1_tuned_child_select
  import ucbts_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cfg_write,
  input  logic [15:0]             cfg_data,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic [31:0]             parent_visits,
  input  logic                    parity_negative,
  input  logic                    pass_allowed,
  input  logic [15:0]             child_value,
  input  logic [31:0]             child_visits,
  input  logic                    child_is_pass,
  input  logic                    last_child,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic [8:0]              best_index,
  output logic signed [URG_W-1:0] chosen_urgency,
  output logic                    any_considered
);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_LN     = 4'd1;
  localparam logic [3:0] S_LNMUL  = 4'd2;
  localparam logic [3:0] S_XMUL   = 4'd3;
  localparam logic [3:0] S_VMUL   = 4'd4;
  localparam logic [3:0] S_DIV    = 4'd5;
  localparam logic [3:0] S_SQRT   = 4'd6;
  localparam logic [3:0] S_LOC    = 4'd7;
  localparam logic [3:0] S_LOCMUL = 4'd8;
  localparam logic [3:0] S_URG    = 4'd9;
  localparam logic [3:0] S_UPD    = 4'd10;

  logic [3:0]  state;
  logic [4:0]  cnt;
  logic        second;
  logic [15:0] explore_gain;

  // item fields held for the work
  logic        neg;
  logic        last;
  logic        consider;
  logic [15:0] v;
  logic [31:0] n;

  logic [31:0] m;
  logic [15:0] frac;
  logic [4:0]  top;
  logic [24:0] lx;
  logic [16:0] var_q;
  logic [24:0] dvd;
  logic [31:0] rem;
  logic [41:0] xs;
  logic [41:0] root;
  logic [41:0] bitr;
  logic [14:0] loc;
  logic signed [URG_W-1:0] urg;

  logic signed [URG_W-1:0] run_best;
  logic [IDX_W-1:0]        run_idx;
  logic [IDX_W-1:0]        child_counter;
  logic                    seen_any;

  // shared units
  logic [31:0] mul_a, mul_b;
  logic [63:0] prod;
  logic [42:0] sub_a, sub_b, diff;
  logic        ge;

  always_comb begin
    mul_a = m;
    mul_b = m;
    case (state)
      S_LNMUL: begin
        mul_a = {11'd0, top, frac};
        mul_b = {16'd0, LN2_Q16};
      end
      S_XMUL: begin
        mul_a = {7'd0, lx};
        mul_b = {16'd0, explore_gain};
      end
      S_VMUL: begin
        mul_a = {16'd0, v};
        mul_b = {16'd0, v};
      end
      S_LOCMUL: begin
        mul_a = {7'd0, lx};
        mul_b = {17'd0, loc};
      end
      default: begin
        mul_a = m;
        mul_b = m;
      end
    endcase
  end
  assign prod = mul_a * mul_b;

  always_comb begin
    if (state == S_DIV) begin
      sub_a = {10'd0, rem, dvd[24]};
      sub_b = {11'd0, n};
    end else begin
      sub_a = {1'b0, xs};
      sub_b = {1'b0, root + bitr};
    end
  end
  assign diff = sub_a - sub_b;
  assign ge   = ~diff[42];

  // highest set bit of the parent count
  logic [4:0] top_in;
  always_comb begin
    top_in = 5'd0;
    for (int i = 0; i < 32; i++) begin
      if (parent_visits[i]) top_in = 5'(i);
    end
  end

  logic [32:0] sq;
  assign sq = prod[63:31];

  logic [15:0] vv;
  logic [16:0] var_raw;
  assign vv      = prod[31:16];
  assign var_raw = {1'b0, v} - {1'b0, vv};

  logic [24:0] dvd_next;
  assign dvd_next = {dvd[23:0], ge};

  logic [21:0] loc_sum;
  assign loc_sum = {5'd0, var_q} + {1'b0, root[20:0]};

  logic signed [24:0] sv, usum;
  assign sv   = neg ? -$signed({9'd0, v}) : $signed({9'd0, v});
  assign usum = sv + $signed({4'd0, root[20:0]});

  // best after this child
  logic                    take;
  logic                    seen_next;
  logic signed [URG_W-1:0] best_next;
  logic [IDX_W-1:0]        idx_next;
  assign take      = consider && (!seen_any || (urg > run_best));
  assign seen_next = seen_any || consider;
  assign best_next = take ? urg : run_best;
  assign idx_next  = take ? child_counter : run_idx;

  logic emit;
  assign emit = (state == S_UPD) && last && (!out_valid || !out_stall);

  assign in_stall = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      explore_gain <= GAIN_RESET;
    end else if (cfg_write) begin
      explore_gain <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      cnt           <= 5'd0;
      second        <= 1'b0;
      out_valid     <= 1'b0;
      run_best      <= URG_MIN;
      run_idx       <= '0;
      child_counter <= '0;
      seen_any      <= 1'b0;
    end else begin
      if (emit) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            neg      <= parity_negative;
            last     <= last_child;
            v        <= child_value;
            n        <= child_visits;
            consider <= pass_allowed || !child_is_pass;
            top      <= top_in;
            m        <= parent_visits << (5'd31 - top_in);
            frac     <= 16'd0;
            cnt      <= 5'd0;
            urg      <= URG_MAX;
            if (!(pass_allowed || !child_is_pass) || child_visits == 32'd0
                || parent_visits == 32'd0) begin
              state <= S_UPD;
            end else begin
              state <= S_LN;
            end
          end
        end
        S_LN: begin
          if (sq[32]) begin
            m    <= sq[32:1];
            frac <= {frac[14:0], 1'b1};
          end else begin
            m    <= sq[31:0];
            frac <= {frac[14:0], 1'b0};
          end
          cnt <= cnt + 5'd1;
          if (cnt == LN_STEPS - 5'd1) state <= S_LNMUL;
        end
        S_LNMUL: begin
          lx    <= {4'd0, prod[36:16]};
          state <= S_XMUL;
        end
        S_XMUL: begin
          lx    <= prod[36:12];
          state <= S_VMUL;
        end
        S_VMUL: begin
          var_q  <= neg ? (17'h10000 - var_raw) : var_raw;
          dvd    <= lx;
          rem    <= 32'd0;
          cnt    <= 5'd0;
          second <= 1'b0;
          state  <= S_DIV;
        end
        S_DIV: begin
          rem <= ge ? diff[31:0] : {rem[30:0], dvd[24]};
          dvd <= dvd_next;
          cnt <= cnt + 5'd1;
          if (cnt == DIV_STEPS - 5'd1) begin
            // set up the root of quotient << 16
            xs    <= {1'b0, dvd_next, 16'd0};
            root  <= 42'd0;
            bitr  <= 42'd1 << 40;
            cnt   <= 5'd0;
            state <= S_SQRT;
          end
        end
        S_SQRT: begin
          if (ge) begin
            xs   <= diff[41:0];
            root <= (root >> 1) + bitr;
          end else begin
            root <= root >> 1;
          end
          bitr <= bitr >> 2;
          cnt  <= cnt + 5'd1;
          if (cnt == SQRT_STEPS - 5'd1) state <= second ? S_URG : S_LOC;
        end
        S_LOC: begin
          loc   <= (loc_sum > {7'd0, QUARTER_Q16}) ? QUARTER_Q16 : loc_sum[14:0];
          state <= S_LOCMUL;
        end
        S_LOCMUL: begin
          dvd    <= prod[40:16];
          rem    <= 32'd0;
          cnt    <= 5'd0;
          second <= 1'b1;
          state  <= S_DIV;
        end
        S_URG: begin
          if (usum > 25'sd4194303) urg <= URG_MAX;
          else if (usum < -25'sd4194304) urg <= URG_MIN;
          else urg <= usum[URG_W-1:0];
          state <= S_UPD;
        end
        S_UPD: begin
          if (!last) begin
            run_best      <= best_next;
            run_idx       <= idx_next;
            seen_any      <= seen_next;
            child_counter <= child_counter + 1'b1;
            state         <= S_IDLE;
          end else if (!out_valid || !out_stall) begin
            // emit and clear for the next node
            any_considered <= seen_next;
            best_index     <= seen_next ? 9'(idx_next) : 9'd0;
            chosen_urgency <= seen_next ? best_next : URG_MIN;
            run_best       <= URG_MIN;
            run_idx        <= '0;
            seen_any       <= 1'b0;
            child_counter  <= '0;
            state          <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

FILE: src/ucbts_checker.sv
// Port-level checker for the child select block, bound to the top level.
// Depends on ucbts_pkg and ucb1_tuned_child_select_macros.svh.
`include "ucb1_tuned_child_select_macros.svh"
module ucbts_checker
  import ucbts_pkg::*;
(
  input logic                    clk,
  input logic                    rst,
  input logic                    in_valid,
  input logic                    in_stall,
  input logic                    out_valid,
  input logic                    out_stall,
  input logic [8:0]              best_index,
  input logic signed [URG_W-1:0] chosen_urgency,
  input logic                    any_considered
);

  `UCBTS_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(best_index) && $stable(chosen_urgency))
  `UCBTS_ASSERT_NOW(a_empty_node, out_valid && !any_considered, best_index == 9'd0 && chosen_urgency == URG_MIN)
  `UCBTS_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall)
  `UCBTS_ASSERT_NOW(a_result_after_work, $rose(out_valid), $past(in_stall))

endmodule

bind ucb1_tuned_child_select ucbts_checker u_ucbts_checker (
  .clk            (clk),
  .rst            (rst),
  .in_valid       (in_valid),
  .in_stall       (in_stall),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .best_index     (best_index),
  .chosen_urgency (chosen_urgency),
  .any_considered (any_considered)
);
